// ===== design/facl_pkg.sv =====
// package for the five-tuple acl filter: types, constants, field positions
// no dependencies
`default_nettype none
package facl_pkg;
    localparam int unsigned DEFAULT_TABLE_ENTRIES = 1024;
    localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP = 8'd6;
    localparam logic [7:0]  PROTO_UDP = 8'd17;
    localparam logic [15:0] ETH_LEN = 16'd14;
    localparam logic [15:0] IP_MIN_END = 16'd34;
    localparam logic [15:0] TCP_LEN = 16'd20;
    localparam logic [15:0] UDP_LEN = 16'd8;
    localparam logic [14:0] VERDICT_MALFORMED = 15'h7FFF;
    localparam logic [14:0] VERDICT_PASS = 15'd0;
    localparam logic        CMD_BYTE = 1'b0;
    localparam logic        CMD_RULE = 1'b1;
    localparam logic        KIND_FRAME = 1'b0;
    localparam logic        KIND_RULE = 1'b1;

    typedef struct packed {
        logic [31:0] src_addr;
        logic [31:0] dst_addr;
        logic [15:0] src_port;
        logic [15:0] dst_port;
        logic [7:0]  protocol;
    } t_tuple;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_OUT
    } t_state;

    // controller to datapath
    typedef struct packed {
        logic start_scan;   // latch key, clear scan index
        logic step_scan;    // advance scan index
        logic write_entry;  // store rule at hit or next free
        logic load_result;  // set output valid; a direct verdict is placed into the output register here
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic scan_done;
        logic scan_hit;
        logic direct;       // frame verdict known without a lookup
    } t_status;
endpackage
`default_nettype wire

// ===== design/facl_if.sv =====
// stream interfaces for input items and results
// no dependencies
`default_nettype none
interface facl_in_if;
    logic        valid;
    logic        ready;
    logic        command;
    logic [7:0]  packet_byte;
    logic        last_byte;
    logic [31:0] rule_src_addr;
    logic [31:0] rule_dst_addr;
    logic [15:0] rule_src_port;
    logic [15:0] rule_dst_port;
    logic [7:0]  rule_protocol;
    logic signed [14:0] rule_verdict;
    modport source (output valid, command, packet_byte, last_byte, rule_src_addr,
        rule_dst_addr, rule_src_port, rule_dst_port, rule_protocol, rule_verdict,
        input ready);
    modport sink (input valid, command, packet_byte, last_byte, rule_src_addr,
        rule_dst_addr, rule_src_port, rule_dst_port, rule_protocol, rule_verdict,
        output ready);
endinterface

interface facl_out_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic signed [14:0] verdict;
    logic        load_status;
    modport source (output valid, result_kind, verdict, load_status, input ready);
    modport sink (input valid, result_kind, verdict, load_status, output ready);
endinterface
`default_nettype wire

// ===== design/five_tuple_acl_filter.sv =====
// top level of the five-tuple acl filter: controller and datapath
// depends on facl_pkg, facl_if, facl_ctrl, facl_dp
//
// channel   dir  transfer on       payload
// s_in      in   valid & ready     command, packet_byte, last_byte, rule_*
// m_out     out  valid & ready     result_kind, verdict, load_status
//
// a packet byte that is not last leaves the block ready for the next byte
// a rule write, or a last byte whose verdict needs a lookup, scans the table, one entry a cycle
// the table lives in key and verdict memories read at one shared address, which sets the scan length
// reset clears capture state, entry count and output valid; the table needs no clear
// input waits while a result sits unaccepted in the output register
`default_nettype none
module five_tuple_acl_filter #(
    parameter int unsigned TABLE_ENTRIES = facl_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    facl_in_if.sink    s_in,
    facl_out_if.source m_out
);
    import facl_pkg::*;

    t_cmd    cmd;
    t_status status;
    logic    in_ready, out_busy, in_xfer;
    logic [14:0] verdict_bits;

    assign s_in.ready = in_ready;
    assign in_xfer = s_in.valid && in_ready;

    facl_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_xfer(in_xfer),
        .i_command(s_in.command), .i_last_byte(s_in.last_byte),
        .i_status(status), .i_out_busy(out_busy), .o_cmd(cmd), .o_in_ready(in_ready)
    );

    facl_dp #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_xfer(in_xfer),
        .i_command(s_in.command), .i_packet_byte(s_in.packet_byte),
        .i_last_byte(s_in.last_byte),
        .i_rule({s_in.rule_src_addr, s_in.rule_dst_addr, s_in.rule_src_port,
                 s_in.rule_dst_port, s_in.rule_protocol}),
        .i_rule_verdict(s_in.rule_verdict), .i_cmd(cmd), .i_out_ready(m_out.ready),
        .o_status(status), .o_out_busy(out_busy), .o_out_valid(m_out.valid),
        .o_result_kind(m_out.result_kind), .o_verdict(verdict_bits),
        .o_load_status(m_out.load_status)
    );

    assign m_out.verdict = verdict_bits;
endmodule
`default_nettype wire

// ===== design/facl_ctrl.sv =====
// controller: sequences header capture, table scan, rule write and result
// depends on facl_pkg
`default_nettype none
module facl_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_xfer,
    input  wire logic             i_command,
    input  wire logic             i_last_byte,
    input  wire facl_pkg::t_status i_status,
    input  wire logic             i_out_busy,
    output facl_pkg::t_cmd        o_cmd,
    output logic                  o_in_ready
);
    import facl_pkg::*;

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = !i_out_busy;
                if (i_in_xfer) begin
                    if (i_command == CMD_RULE) begin
                        o_cmd.start_scan = 1'b1;
                        n_state = ST_SCAN;
                    end else if (i_last_byte) begin
                        o_cmd.start_scan = 1'b1;
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (i_status.direct) begin
                    n_state = ST_OUT;
                end else if (i_status.scan_done || i_status.scan_hit) begin
                    n_state = ST_WRITE;
                end else begin
                    o_cmd.step_scan = 1'b1;
                end
            end
            ST_WRITE: begin
                o_cmd.write_entry = 1'b1;
                n_state = ST_OUT;
            end
            ST_OUT: begin
                o_cmd.load_result = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ===== design/facl_dp.sv =====
// datapath: header capture registers, rule table memory, scan and result
// depends on facl_pkg
`default_nettype none
module facl_dp #(
    parameter int unsigned TABLE_ENTRIES = facl_pkg::DEFAULT_TABLE_ENTRIES
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_xfer,
    input  wire logic              i_command,
    input  wire logic [7:0]        i_packet_byte,
    input  wire logic              i_last_byte,
    input  wire facl_pkg::t_tuple  i_rule,
    input  wire logic [14:0]       i_rule_verdict,
    input  wire facl_pkg::t_cmd    i_cmd,
    input  wire logic              i_out_ready,
    output facl_pkg::t_status      o_status,
    output logic                   o_out_busy,
    output logic                   o_out_valid,
    output logic                   o_result_kind,
    output logic [14:0]            o_verdict,
    output logic                   o_load_status
);
    import facl_pkg::*;

    localparam int unsigned IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CW-1:0] FULL = CW'(TABLE_ENTRIES);

    logic [15:0] r_offset;
    logic [15:0] r_ether_type;
    logic [3:0]  r_ihl;
    logic [7:0]  r_proto;
    logic [31:0] r_src, r_dst;
    logic [15:0] r_sport, r_dport;

    t_tuple      r_key;
    logic [14:0] r_new_verdict;
    logic        r_is_rule;
    logic        r_direct;
    logic [14:0] r_direct_v;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_scan;
    logic          r_rd_valid;
    logic [IW-1:0] r_rd_idx;
    logic          r_hit;
    logic [IW-1:0] r_hit_idx;
    logic [14:0]   r_hit_v;

    t_tuple      mem_key [TABLE_ENTRIES];
    logic [14:0] mem_v   [TABLE_ENTRIES];
    t_tuple      r_rd_key;
    logic [14:0] r_rd_v;

    logic [15:0] pos, l4, len, need;
    logic        in_byte, rd_match;
    logic        n_direct;
    logic [14:0] n_direct_v;
    logic [15:0] n_sport, n_dport;
    logic [3:0]  ihl_now;
    logic [15:0] et_now;
    logic [7:0]  proto_now;
    logic [31:0] src_now, dst_now;

    logic          r_out_valid;
    logic          r_out_kind;
    logic [14:0]   r_out_v;
    logic          r_out_status;

    assign in_byte = i_in_xfer && (i_command == CMD_BYTE);
    assign pos = r_offset;
    assign len = (r_offset == 16'hFFFF) ? r_offset : r_offset + 16'd1;

    // capture of the current byte, combined into the values seen at the end
    always_comb begin
        et_now = r_ether_type;
        ihl_now = r_ihl;
        proto_now = r_proto;
        src_now = r_src;
        dst_now = r_dst;
        n_sport = r_sport;
        n_dport = r_dport;
        if (pos == 16'd12) et_now = {i_packet_byte, r_ether_type[7:0]};
        else if (pos == 16'd13) et_now = {r_ether_type[15:8], i_packet_byte};
        else if (pos == 16'd14) ihl_now = i_packet_byte[3:0];
        else if (pos == 16'd23) proto_now = i_packet_byte;
        else if (pos >= 16'd26 && pos <= 16'd29) src_now = {r_src[23:0], i_packet_byte};
        else if (pos >= 16'd30 && pos <= 16'd33) dst_now = {r_dst[23:0], i_packet_byte};
        l4 = ETH_LEN + {10'd0, r_ihl, 2'b00};
        if (r_ihl >= 4'd5 && pos > 16'd14) begin
            if (pos == l4 || pos == l4 + 16'd1) n_sport = {r_sport[7:0], i_packet_byte};
            else if (pos == l4 + 16'd2 || pos == l4 + 16'd3)
                n_dport = {r_dport[7:0], i_packet_byte};
        end
    end

    always_comb begin
        need = ETH_LEN + {10'd0, ihl_now, 2'b00}
            + ((proto_now == PROTO_TCP) ? TCP_LEN : UDP_LEN);
        n_direct = 1'b1;
        n_direct_v = VERDICT_PASS;
        priority if (len < ETH_LEN) n_direct_v = VERDICT_MALFORMED;
        else if (et_now != ETHERTYPE_IPV4) n_direct_v = VERDICT_PASS;
        else if (len < IP_MIN_END) n_direct_v = VERDICT_MALFORMED;
        else if (ihl_now < 4'd5) n_direct_v = VERDICT_MALFORMED;
        else if (proto_now != PROTO_TCP && proto_now != PROTO_UDP)
            n_direct_v = VERDICT_PASS;
        else if (len < need) n_direct_v = VERDICT_MALFORMED;
        else n_direct = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= '0;
            r_ether_type <= '0;
            r_ihl <= '0;
            r_proto <= '0;
            r_src <= '0;
            r_dst <= '0;
            r_sport <= '0;
            r_dport <= '0;
        end else if (in_byte) begin
            if (i_last_byte) begin
                r_offset <= '0;
                r_ether_type <= '0;
                r_ihl <= '0;
                r_proto <= '0;
                r_src <= '0;
                r_dst <= '0;
                r_sport <= '0;
                r_dport <= '0;
            end else begin
                r_offset <= len;
                r_ether_type <= et_now;
                r_ihl <= ihl_now;
                r_proto <= proto_now;
                r_src <= src_now;
                r_dst <= dst_now;
                r_sport <= n_sport;
                r_dport <= n_dport;
            end
        end
    end

    // lookup key and scan
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_scan) begin
            r_is_rule <= i_command;
            r_new_verdict <= i_rule_verdict;
            r_direct_v <= n_direct_v;
            if (i_command == CMD_RULE) r_key <= i_rule;
            else r_key <= '{src_now, dst_now, n_sport, n_dport, proto_now};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direct <= 1'b0;
            r_scan <= '0;
            r_rd_valid <= 1'b0;
            r_hit <= 1'b0;
        end else if (i_cmd.start_scan) begin
            r_direct <= (i_command == CMD_BYTE) && n_direct;
            r_scan <= '0;
            r_rd_valid <= 1'b0;
            r_hit <= 1'b0;
        end else if (i_cmd.step_scan) begin
            if (r_scan < r_count) begin
                r_rd_idx <= r_scan[IW-1:0];
                r_scan <= r_scan + 1'b1;
                r_rd_valid <= 1'b1;
            end else begin
                r_rd_valid <= 1'b0;
            end
            if (rd_match) begin
                r_hit <= 1'b1;
                r_hit_idx <= r_rd_idx;
                r_hit_v <= r_rd_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key <= mem_key[r_scan[IW-1:0]];
        r_rd_v <= mem_v[r_scan[IW-1:0]];
    end

    assign rd_match = r_rd_valid && !r_hit && (r_rd_key == r_key);
    assign o_status.scan_hit = r_hit;
    assign o_status.scan_done = !r_rd_valid && (r_scan >= r_count);
    assign o_status.direct = r_direct;

    // table write
    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry && r_is_rule) begin
            if (r_hit) begin
                mem_v[r_hit_idx] <= r_new_verdict;
            end else if (r_count < FULL) begin
                mem_key[r_count[IW-1:0]] <= r_key;
                mem_v[r_count[IW-1:0]] <= r_new_verdict;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.write_entry && r_is_rule && !r_hit && r_count < FULL) begin
            r_count <= r_count + 1'b1;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_result) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.write_entry) begin
            r_out_kind <= r_is_rule ? KIND_RULE : KIND_FRAME;
            r_out_status <= r_is_rule && !r_hit && (r_count >= FULL);
            r_out_v <= r_is_rule ? VERDICT_PASS : (r_hit ? r_hit_v : VERDICT_PASS);
        end else if (i_cmd.load_result && r_direct) begin
            r_out_kind <= KIND_FRAME;
            r_out_status <= 1'b0;
            r_out_v <= r_direct_v;
        end
    end

    assign o_out_busy = r_out_valid;
    assign o_out_valid = r_out_valid;
    assign o_result_kind = r_out_kind;
    assign o_verdict = r_out_v;
    assign o_load_status = r_out_status;
endmodule
`default_nettype wire

// ===== test/tb_scoreboard.sv =====
// frame verdict predictor and result checker for the five-tuple acl filter
// depends on facl_pkg
`timescale 1ns / 100ps
`default_nettype none
class acl_scoreboard;
    localparam int ENTRIES = facl_pkg::DEFAULT_TABLE_ENTRIES;

    logic [15:0] offset;
    logic [15:0] etype;
    logic [3:0]  ihl;
    logic [7:0]  proto;
    logic [31:0] saddr, daddr;
    logic [15:0] sport, dport;

    facl_pkg::t_tuple rule_key[ENTRIES];
    logic [14:0] rule_val[ENTRIES];
    int unsigned rule_count;

    logic [16:0] pending_results[$];
    int unsigned error_count;

    function new();
        rule_count = 0;
        error_count = 0;
        clear_capture();
    endfunction

    function void clear_capture();
        offset = '0; etype = '0; ihl = '0; proto = '0;
        saddr = '0; daddr = '0; sport = '0; dport = '0;
    endfunction

    function int find_rule(facl_pkg::t_tuple key);
        for (int i = 0; i < rule_count; i++)
            if (rule_key[i] == key) return i;
        return -1;
    endfunction

    function logic [14:0] classify(int unsigned len);
        int unsigned l4, need;
        facl_pkg::t_tuple key;
        int idx;
        if (len < facl_pkg::ETH_LEN) return facl_pkg::VERDICT_MALFORMED;
        if (etype != facl_pkg::ETHERTYPE_IPV4) return facl_pkg::VERDICT_PASS;
        if (len < facl_pkg::IP_MIN_END) return facl_pkg::VERDICT_MALFORMED;
        if (ihl < 5) return facl_pkg::VERDICT_MALFORMED;
        l4 = 14 + 4 * ihl;
        if (proto == facl_pkg::PROTO_TCP) need = l4 + 20;
        else if (proto == facl_pkg::PROTO_UDP) need = l4 + 8;
        else return facl_pkg::VERDICT_PASS;
        if (len < need) return facl_pkg::VERDICT_MALFORMED;
        key = '{saddr, daddr, sport, dport, proto};
        idx = find_rule(key);
        return (idx >= 0) ? rule_val[idx] : facl_pkg::VERDICT_PASS;
    endfunction

    // note one accepted input transfer
    function void note_input(logic cmd, logic [7:0] b, logic last, facl_pkg::t_tuple key,
                             logic [14:0] vrd);
        int idx;
        int unsigned pos, l4;
        if (cmd == facl_pkg::CMD_RULE) begin
            idx = find_rule(key);
            if (idx < 0 && rule_count >= ENTRIES) begin
                pending_results.push_back({facl_pkg::KIND_RULE, 15'd0, 1'b1});
                return;
            end
            if (idx < 0) begin
                idx = rule_count;
                rule_count++;
                rule_key[idx] = key;
            end
            rule_val[idx] = vrd;
            pending_results.push_back({facl_pkg::KIND_RULE, 15'd0, 1'b0});
            return;
        end
        pos = offset;
        if (pos == 12) etype[15:8] = b;
        else if (pos == 13) etype[7:0] = b;
        else if (pos == 14) ihl = b[3:0];
        else if (pos == 23) proto = b;
        else if (pos >= 26 && pos <= 29) saddr = {saddr[23:0], b};
        else if (pos >= 30 && pos <= 33) daddr = {daddr[23:0], b};
        if (ihl >= 5 && pos > 14) begin
            l4 = 14 + 4 * ihl;
            if (pos == l4 || pos == l4 + 1) sport = {sport[7:0], b};
            else if (pos == l4 + 2 || pos == l4 + 3) dport = {dport[7:0], b};
        end
        if (offset != 16'hFFFF) offset++;
        if (last) begin
            pending_results.push_back({facl_pkg::KIND_FRAME, classify(offset), 1'b0});
            clear_capture();
        end
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(logic kind, logic [14:0] vrd, logic status);
        logic [16:0] want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result kind=%0d verdict=%0d status=%0d",
                     $time, kind, vrd, status);
            error_count++;
            return;
        end
        want = pending_results.pop_front();
        if (want != {kind, vrd, status}) begin
            $display("%0t: result mismatch expected kind=%0d verdict=%h status=%0d, actual kind=%0d verdict=%h status=%0d",
                     $time, want[16], want[15:1], want[0], kind, vrd, status);
            error_count++;
        end
    endfunction
endclass
`default_nettype wire

// ===== test/tb.sv =====
// testbench top for five_tuple_acl_filter: frame and rule stimulus, random idling
// depends on facl_pkg, facl_if, tb_scoreboard and the design
`timescale 1ns / 100ps
`default_nettype none
module tb;
    import facl_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    always #5 i_clk = ~i_clk;

    facl_in_if  in_ch();
    facl_out_if out_ch();

    five_tuple_acl_filter i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .s_in(in_ch.sink), .m_out(out_ch.source)
    );

    acl_scoreboard board = new();
    bit no_idle = 1'b0;
    bit inputs_done = 1'b0;
    int unsigned quiet_cycles = 0;
    int unsigned frame_count = 0;
    t_tuple known_rules[$];
    byte unsigned frame_buf[$];

    initial begin
        in_ch.valid = 1'b0; in_ch.command = CMD_BYTE; in_ch.packet_byte = '0;
        in_ch.last_byte = 1'b0; in_ch.rule_src_addr = '0; in_ch.rule_dst_addr = '0;
        in_ch.rule_src_port = '0; in_ch.rule_dst_port = '0; in_ch.rule_protocol = '0;
        in_ch.rule_verdict = '0; out_ch.ready = 1'b0;
    end

    // result sink with random stall bursts
    initial begin
        int unsigned stall;
        stall = 0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (stall == 0 && !no_idle && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 18);
            out_ch.ready <= (stall == 0);
            if (stall != 0) stall--;
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready)
                board.check_result(out_ch.result_kind, out_ch.verdict, out_ch.load_status);
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 20000) begin
            $display("tb: errors");
            $finish;
        end
    end

    task automatic send_item(logic cmd, logic [7:0] b, logic last, t_tuple key,
                             logic [14:0] vrd);
        int unsigned gap;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 18);
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.command <= cmd;
        in_ch.packet_byte <= b;
        in_ch.last_byte <= last;
        in_ch.rule_src_addr <= key.src_addr;
        in_ch.rule_dst_addr <= key.dst_addr;
        in_ch.rule_src_port <= key.src_port;
        in_ch.rule_dst_port <= key.dst_port;
        in_ch.rule_protocol <= key.protocol;
        in_ch.rule_verdict <= vrd;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        board.note_input(cmd, b, last, key, vrd);
    endtask

    task automatic add_rule(t_tuple key, logic [14:0] vrd);
        send_item(CMD_RULE, 8'($urandom), 1'($urandom), key, vrd);
        known_rules.push_back(key);
    endtask

    function automatic t_tuple random_tuple();
        t_tuple key;
        key.src_addr = $urandom;
        key.dst_addr = $urandom;
        key.src_port = 16'($urandom);
        key.dst_port = 16'($urandom);
        case ($urandom_range(0, 4))
            0, 1: key.protocol = PROTO_TCP;
            2, 3: key.protocol = PROTO_UDP;
            default: key.protocol = 8'($urandom);
        endcase
        return key;
    endfunction

    // build a frame for the tuple, with a bad ethertype if asked, then send it truncated or padded
    task automatic send_frame(t_tuple key, logic [3:0] ihl, int trim, bit bad_type);
        int unsigned l4, len;
        t_tuple noise;
        frame_buf.delete();
        l4 = 14 + 4 * ((ihl < 5) ? 5 : ihl);
        len = l4 + ((key.protocol == PROTO_TCP) ? 20 : 8) + $urandom_range(0, 6);
        for (int i = 0; i < len; i++) frame_buf.push_back(8'($urandom));
        frame_buf[12] = bad_type ? 8'($urandom) : 8'h08;
        frame_buf[13] = bad_type ? 8'($urandom) : 8'h00;
        frame_buf[14] = {4'($urandom), ihl};
        frame_buf[23] = key.protocol;
        for (int i = 0; i < 4; i++) begin
            frame_buf[26 + i] = key.src_addr[31 - 8 * i -: 8];
            frame_buf[30 + i] = key.dst_addr[31 - 8 * i -: 8];
        end
        frame_buf[l4] = key.src_port[15:8];
        frame_buf[l4 + 1] = key.src_port[7:0];
        frame_buf[l4 + 2] = key.dst_port[15:8];
        frame_buf[l4 + 3] = key.dst_port[7:0];
        len = (trim >= 0 && trim < len) ? trim : len;
        noise = random_tuple();
        for (int i = 0; i < len; i++) begin
            // rule writes interleaved inside a frame
            if ($urandom_range(0, 60) == 0)
                add_rule(random_tuple(), 15'($urandom_range(0, 9999)));
            send_item(CMD_BYTE, frame_buf[i], i == len - 1, noise, 15'($urandom));
        end
        frame_count++;
    endtask

    initial begin
        t_tuple key;
        logic [14:0] vrd;
        int pick;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        send_item(CMD_BYTE, 8'h00, 1'b1, '0, '0);
        send_item(CMD_BYTE, 8'hFF, 1'b1, '1, '1);
        key = '{32'h0A000001, 32'hFFFFFFFF, 16'h0000, 16'hFFFF, PROTO_TCP};
        add_rule(key, 15'h7FFF);
        send_frame(key, 4'd5, -1, 1'b0);
        add_rule(key, 15'd9999);
        send_frame(key, 4'd15, -1, 1'b0);
        send_frame(key, 4'd5, 13, 1'b0);
        send_frame(key, 4'd5, 33, 1'b0);
        send_frame(key, 4'd4, -1, 1'b0);
        send_frame(key, 4'd0, -1, 1'b0);
        send_frame(key, 4'd5, 53, 1'b0);
        send_frame(key, 4'd5, -1, 1'b1);
        key = '{32'h0, 32'h0, 16'hFFFF, 16'h0, PROTO_UDP};
        add_rule(key, 15'd1);
        send_frame(key, 4'd6, -1, 1'b0);
        send_frame(key, 4'd6, 41, 1'b0);
        key.protocol = 8'hFF;
        add_rule(key, 15'd5);
        send_frame(key, 4'd5, -1, 1'b0);
        send_frame(random_tuple(), 4'd5, -1, 1'b0);

        // random part: mostly good frames, some rules, some damaged frames
        while (frame_count < 34) begin
            if (frame_count > 29) no_idle = 1'b1;
            if ($urandom_range(0, 2) == 0) begin
                add_rule(random_tuple(), ($urandom_range(0, 9) == 0) ? 15'h7FFF
                         : 15'($urandom_range(0, 9999)));
            end
            if (known_rules.size() != 0 && $urandom_range(0, 2) != 0)
                key = known_rules[$urandom_range(0, known_rules.size() - 1)];
            else
                key = random_tuple();
            if (key.protocol != PROTO_TCP && key.protocol != PROTO_UDP
                && $urandom_range(0, 1) == 0)
                key.protocol = PROTO_UDP;
            pick = $urandom_range(0, 9);
            send_frame(key, (pick == 0) ? 4'($urandom) : 4'($urandom_range(5, 7)),
                       (pick == 1) ? int'($urandom_range(1, 60)) : -1, pick == 2);
        end
        // overwrite a known rule with an extreme value
        if (known_rules.size() != 0) begin
            add_rule(known_rules[0], 15'h3FFF);
            send_frame(known_rules[0], 4'd5, -1, 1'b0);
        end
        in_ch.valid <= 1'b0;
        inputs_done = 1'b1;

        while (board.pending_results.size() != 0) @(posedge i_clk);
        repeat (1100) @(posedge i_clk);
        if (board.error_count == 0 && board.pending_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end
endmodule
`default_nettype wire
